FILE: design/ffea_pkg.sv
`default_nettype none
package ffea_pkg;
    localparam int MaxExtents = 16;
    localparam int MaxAllocs  = 16;
    localparam int AllocHdr   = 4;
    localparam int FreeHdr    = 16;
    localparam int ExtIdxW    = $clog2(MaxExtents);
    localparam int ExtCntW    = $clog2(MaxExtents + 1);
    localparam int AllocIdxW  = $clog2(MaxAllocs);
    localparam int AllocCntW  = $clog2(MaxAllocs + 1);
    localparam logic [16:0] HeapReset = 17'd4096;
    localparam logic [16:0] HeapMin   = 17'd64;
    localparam logic [16:0] HeapMax   = 17'd65536;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_code_t;

    typedef struct packed {
        logic [0:0]  func;
        logic [15:0] req_size;
        logic [15:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } rsp_t;
endpackage
`default_nettype wire

FILE: design/ffea_if.sv
`default_nettype none
interface ffea_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  func;
    logic [15:0] req_size;
    logic [15:0] block_addr;
    modport source (output valid, func, req_size, block_addr, input ready);
    modport sink (input valid, func, req_size, block_addr, output ready);
endinterface

interface ffea_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] addr;
    logic [1:0]  status;
    modport source (output valid, addr, status, input ready);
    modport sink (input valid, addr, status, output ready);
endinterface
`default_nettype wire

FILE: design/first_fit_extent_allocator.sv
// First-fit extent allocator. Free space is an address-sorted table of up to
// 16 extents; allocations are kept in a 16-entry table. Each request runs
// through a sequencer that visits one table entry per cycle: an allocate
// scans the extents, then the allocation slots, then cuts the block from its
// extent; a free scans the slots, then the extents, then merges or shifts
// entries. One request is in work at a time; the block is not ready meanwhile.
// Writing heap_size (APB, address 0) resets the heap to one free extent.
`default_nettype none
module first_fit_extent_allocator
    import ffea_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    ffea_req_if.sink         req,
    ffea_rsp_if.source       rsp
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIND  = 10'b0000000010,
        S_SLOT  = 10'b0000000100,
        S_CUT   = 10'b0000001000,
        S_LOOK  = 10'b0000010000,
        S_POS   = 10'b0000100000,
        S_MERGE = 10'b0001000000,
        S_SHL   = 10'b0010000000,
        S_SHR   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [16:0] heap_reg;
    logic [15:0] fs_reg [MaxExtents];
    logic [16:0] fl_reg [MaxExtents];
    logic [ExtCntW-1:0] fcnt_reg;
    logic [15:0] as_reg [MaxAllocs];
    logic [16:0] al_reg [MaxAllocs];
    logic [MaxAllocs-1:0] av_reg;

    logic [ExtCntW-1:0]   i_reg;
    logic [AllocCntW-1:0] slot_reg;
    logic [15:0] ua_reg;
    logic [16:0] blen_reg;
    logic [15:0] s_reg;
    logic [16:0] len_reg;
    logic        rv_reg;
    logic [15:0] raddr_reg;
    logic [1:0]  rstat_reg;

    // apb write and clamp
    logic        cfg_wr;
    logic [16:0] cfg_v;
    assign pready = 1'b1;
    assign prdata = {15'd0, heap_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
    always_comb
    begin
        cfg_v = pwdata[16:0];
        if (cfg_v < HeapMin) cfg_v = HeapMin;
        if (cfg_v > HeapMax) cfg_v = HeapMax;
    end

    assign req.ready  = (state_reg == S_IDLE) && !rv_reg;
    assign rsp.valid  = rv_reg;
    assign rsp.addr   = raddr_reg;
    assign rsp.status = rstat_reg;

    // shared index views
    logic [ExtIdxW-1:0]   ix;
    logic [ExtIdxW-1:0]   ixm;
    logic [AllocIdxW-1:0] sx;
    logic                 i_end;
    logic [16:0]          pend;
    assign ix    = i_reg[ExtIdxW-1:0];
    assign ixm   = ix - 1'b1;
    assign sx    = slot_reg[AllocIdxW-1:0];
    assign i_end = (i_reg >= fcnt_reg);
    assign pend  = {1'b0, fs_reg[ixm]} + fl_reg[ixm];

    // neighbor merge tests
    logic [ExtCntW-1:0] p_reg;
    logic mp, ms;
    assign mp = (i_reg != '0) && (pend == {1'b0, s_reg});
    assign ms = !i_end && ({1'b0, s_reg} + len_reg == {1'b0, fs_reg[ix]});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.valid && req.ready)
                         state_next = (req.func == FUNC_FREE) ? S_LOOK : S_FIND;
            S_FIND:  if (i_end || fl_reg[ix] >= blen_reg + 17'(FreeHdr))
                         state_next = i_end ? S_DONE : S_SLOT;
            S_SLOT:  if (slot_reg == AllocCntW'(MaxAllocs) || !av_reg[sx])
                         state_next = (slot_reg == AllocCntW'(MaxAllocs)) ? S_DONE : S_CUT;
            S_CUT:   state_next = (fl_reg[ix] == blen_reg) ? S_SHL : S_DONE;
            S_LOOK:  if (slot_reg == AllocCntW'(MaxAllocs)) state_next = S_DONE;
                     else if (av_reg[sx] && as_reg[sx] + 16'(AllocHdr) == ua_reg)
                         state_next = S_POS;
            S_POS:   if (i_end || fs_reg[ix] >= s_reg) state_next = S_MERGE;
            S_MERGE: if (mp && ms) state_next = S_SHL;
                     else if (!mp && !ms && fcnt_reg < ExtCntW'(MaxExtents))
                         state_next = S_SHR;
                     else state_next = S_DONE;
            S_SHL:   if (i_reg + 1'b1 >= fcnt_reg) state_next = S_DONE;
            S_SHR:   if (i_reg == p_reg) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            heap_reg  <= HeapReset;
            fcnt_reg  <= ExtCntW'(1);
            av_reg    <= '0;
            rv_reg    <= 1'b0;
            fs_reg[0] <= '0;
            fl_reg[0] <= HeapReset;
        end
        else if (cfg_wr)
        begin
            heap_reg  <= cfg_v;
            fcnt_reg  <= ExtCntW'(1);
            av_reg    <= '0;
            fs_reg[0] <= '0;
            fl_reg[0] <= cfg_v;
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp.valid && rsp.ready) rv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (req.valid && req.ready)
                    begin
                        ua_reg    <= req.block_addr;
                        blen_reg  <= ((req.req_size == 16'd0) ? 17'd1 : {1'b0, req.req_size})
                                     + 17'(AllocHdr);
                        i_reg     <= '0;
                        slot_reg  <= '0;
                        raddr_reg <= '0;
                        rstat_reg <= ST_OK;
                    end
                S_FIND:
                    if (i_end) rstat_reg <= ST_NOFIT;
                    else if (!(fl_reg[ix] >= blen_reg + 17'(FreeHdr))) i_reg <= i_reg + 1'b1;
                S_SLOT:
                    if (slot_reg == AllocCntW'(MaxAllocs)) rstat_reg <= ST_FULL;
                    else if (av_reg[sx]) slot_reg <= slot_reg + 1'b1;
                S_CUT:
                begin
                    av_reg[sx] <= 1'b1;
                    as_reg[sx] <= fs_reg[ix];
                    al_reg[sx] <= blen_reg;
                    raddr_reg  <= fs_reg[ix] + 16'(AllocHdr);
                    fs_reg[ix] <= fs_reg[ix] + blen_reg[15:0];
                    fl_reg[ix] <= fl_reg[ix] - blen_reg;
                end
                S_LOOK:
                    if (slot_reg == AllocCntW'(MaxAllocs)) rstat_reg <= ST_UNKNOWN;
                    else if (av_reg[sx] && as_reg[sx] + 16'(AllocHdr) == ua_reg)
                    begin
                        s_reg   <= as_reg[sx];
                        len_reg <= al_reg[sx];
                    end
                    else slot_reg <= slot_reg + 1'b1;
                S_POS:
                    if (!(i_end || fs_reg[ix] >= s_reg)) i_reg <= i_reg + 1'b1;
                S_MERGE:
                begin
                    p_reg <= i_reg;
                    if (mp && ms)
                    begin
                        fl_reg[ixm] <= fl_reg[ixm] + len_reg + fl_reg[ix];
                        av_reg[sx]  <= 1'b0;
                    end
                    else if (mp)
                    begin
                        fl_reg[ixm] <= fl_reg[ixm] + len_reg;
                        av_reg[sx]  <= 1'b0;
                    end
                    else if (ms)
                    begin
                        fs_reg[ix] <= s_reg;
                        fl_reg[ix] <= fl_reg[ix] + len_reg;
                        av_reg[sx] <= 1'b0;
                    end
                    else if (fcnt_reg >= ExtCntW'(MaxExtents))
                        rstat_reg <= ST_FULL;
                    else
                    begin
                        av_reg[sx] <= 1'b0;
                        i_reg      <= fcnt_reg;
                        fcnt_reg   <= fcnt_reg + 1'b1;
                    end
                end
                S_SHL:
                    if (i_reg + 1'b1 >= fcnt_reg) fcnt_reg <= fcnt_reg - 1'b1;
                    else
                    begin
                        fs_reg[ix] <= fs_reg[ix + 1'b1];
                        fl_reg[ix] <= fl_reg[ix + 1'b1];
                        i_reg      <= i_reg + 1'b1;
                    end
                S_SHR:
                    if (i_reg == p_reg)
                    begin
                        fs_reg[ix] <= s_reg;
                        fl_reg[ix] <= len_reg;
                    end
                    else
                    begin
                        fs_reg[ix] <= fs_reg[ixm];
                        fl_reg[ix] <= fl_reg[ixm];
                        i_reg      <= i_reg - 1'b1;
                    end
                S_DONE:
                    rv_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg != '0 && fcnt_reg <= ExtCntW'(MaxExtents))
        else $error("extent count out of range");
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE) else $error("ready while busy");
    a_done_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !cfg_wr) |=> rv_reg) else $error("result lost");
endmodule
`default_nettype wire
